@@ hdl/g8hist_pkg.sv @@
package g8hist_pkg;

    localparam int NUM_BINS       = 256;
    localparam int BIN_BITS       = 8;
    localparam int OUT_COUNT_BITS = 32;
    localparam int OUT_DATA_BITS  = BIN_BITS + OUT_COUNT_BITS;

    typedef enum logic [0:0] {
        OP_COUNT = 1'b0,
        OP_READ  = 1'b1
    } op_t;

endpackage

@@ hdl/gray8_histogram.sv @@
// gray8_histogram: 256-bin histogram of 8-bit gray pixels.
//
// Input stream (s_*): s_tuser selects the operation, s_tdata carries the pixel
// value or bin index. A count word adds one to the pixel's bin (saturating at
// 2^COUNT_BITS - 1) and produces nothing. A read word returns the bin's count
// on the output stream and clears the bin.
// Output stream (m_*): one word per read word, in input order.
//
// Path: a read word accepted into stage 1 moves on to the output register that
// drives m_tvalid. Throughput: one word per cycle, count and read words
// mixed freely, repeated bins included, unless a read word waits on a full
// output register; set by the single read-modify-write pass over the bin memory
// (registered read, write from stage 1, with a bypass of the just-written value).
//
// Reset clears every bin at once through per-bin valid flags; the block is
// ready right after reset. When m_tready is low and a result is waiting, count
// words keep flowing; a read word parks in the pipeline stage and s_tready
// drops until the output register frees up.
module gray8_histogram #(
    parameter int COUNT_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_or_bin
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [7:0] bin_index, [39:8] bin_count
);

    localparam int BB = g8hist_pkg::BIN_BITS;
    localparam int OB = g8hist_pkg::OUT_COUNT_BITS;

    // bin memory and per-bin valid flags (invalid bin reads as zero)
    logic [COUNT_BITS-1:0]          bin_mem [g8hist_pkg::NUM_BINS];
    logic [g8hist_pkg::NUM_BINS-1:0] bin_valid_reg;

    // read side, registered with the stage-1 word
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic                  fwd_hit_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;

    // stage 1: word whose bin data is available
    logic              s1_valid_reg;
    g8hist_pkg::op_t   s1_op_reg;
    logic [BB-1:0]     s1_bin_reg;

    // output register
    logic              out_valid_reg;
    logic [BB-1:0]     out_bin_reg;
    logic [OB-1:0]     out_count_reg;

    logic                  accept;
    logic                  s1_adv;
    logic [BB-1:0]         rd_addr;
    logic                  wr_en;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] cur_count;
    logic [OB-1:0]         rep_count;
    logic                  out_valid_next;

    assign s1_adv   = s1_valid_reg &&
                      ((s1_op_reg == g8hist_pkg::OP_COUNT) || !out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // keep rereading the parked bin while stage 1 stalls
    assign rd_addr = accept ? s_tdata[BB-1:0] : s1_bin_reg;

    assign cur_count = fwd_hit_reg  ? fwd_data_reg :
                       rd_valid_reg ? rd_data_reg  : '0;

    always_comb
    begin
        wr_en   = s1_adv;
        wr_data = '0;
        if (s1_op_reg == g8hist_pkg::OP_COUNT)
        begin
            if (cur_count == {COUNT_BITS{1'b1}})
                wr_data = cur_count;
            else
                wr_data = cur_count + COUNT_BITS'(1);
        end
    end

    // reported count clamps to 32 bits
    generate
        if (COUNT_BITS > OB)
        begin : g_clamp
            assign rep_count = (cur_count[COUNT_BITS-1:OB] != '0) ? {OB{1'b1}}
                                                                 : cur_count[OB-1:0];
        end
        else if (COUNT_BITS == OB)
        begin : g_same
            assign rep_count = cur_count;
        end
        else
        begin : g_ext
            assign rep_count = {{(OB-COUNT_BITS){1'b0}}, cur_count};
        end
    endgenerate

    always_comb
    begin
        if (s1_adv && (s1_op_reg == g8hist_pkg::OP_READ))
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            bin_mem[s1_bin_reg] <= wr_data;
        rd_data_reg  <= bin_mem[rd_addr];
        fwd_hit_reg  <= wr_en && (s1_bin_reg == rd_addr);
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_op_reg     <= g8hist_pkg::OP_COUNT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                bin_valid_reg[s1_bin_reg] <= 1'b1;
            rd_valid_reg <= bin_valid_reg[rd_addr];
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (accept)
                s1_op_reg <= g8hist_pkg::op_t'(s_tuser);
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_bin_reg <= s_tdata[BB-1:0];
        if (s1_adv && (s1_op_reg == g8hist_pkg::OP_READ))
        begin
            out_bin_reg   <= s1_bin_reg;
            out_count_reg <= rep_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_bin_reg};

endmodule

@@ test/gray8_histogram_tb.sv @@
`timescale 1ns / 1ps

module gray8_histogram_tb;

    // Counter width of the instance. The predictor follows any width, but
    // the saturation burst in the directed part is only cheap when narrow.
    localparam int CNT_BITS   = 32;
    localparam int TIMEOUT_NS = 20_000_000;  // overall simulation time limit

    typedef struct {
        logic [g8hist_pkg::BIN_BITS-1:0]       bin;
        logic [g8hist_pkg::OUT_COUNT_BITS-1:0] count;
    } bin_report_t;

    // Tracks every bin as the block should, and queues the report each read
    // word must produce.
    class hist_scoreboard;
        longint unsigned tally [g8hist_pkg::NUM_BINS];
        longint unsigned tally_max;
        bin_report_t     pending_reads [$];
        int              errors;
        int              counts_sent;
        int              reads_sent;
        int              reports_seen;

        function new();
            foreach (tally[i])
                tally[i] = 0;
            tally_max    = (CNT_BITS >= 64) ? '1 : ((64'd1 << CNT_BITS) - 1);
            errors       = 0;
            counts_sent  = 0;
            reads_sent   = 0;
            reports_seen = 0;
        endfunction

        // Apply one accepted input word.
        function void note_word(g8hist_pkg::op_t op, logic [7:0] pix);
            bin_report_t rpt;
            if (op == g8hist_pkg::OP_COUNT)
            begin
                counts_sent++;
                if (tally[pix] < tally_max)
                    tally[pix]++;
            end
            else
            begin
                reads_sent++;
                rpt.bin   = pix;
                // wide counters clamp on the way out only
                rpt.count = (tally[pix] > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                         : tally[pix][31:0];
                pending_reads.push_back(rpt);
                tally[pix] = 0;
            end
        endfunction

        // Compare one accepted output word with the oldest pending report.
        function void check_word(logic [g8hist_pkg::OUT_DATA_BITS-1:0] word);
            bin_report_t exp_rpt;
            logic [g8hist_pkg::BIN_BITS-1:0]       got_bin;
            logic [g8hist_pkg::OUT_COUNT_BITS-1:0] got_count;
            got_bin   = word[7:0];
            got_count = word[39:8];
            reports_seen++;
            if (pending_reads.size() == 0)
            begin
                $display("%0t: unexpected report, expected none, got bin=%0d count=%0d",
                         $time, got_bin, got_count);
                errors++;
                return;
            end
            exp_rpt = pending_reads.pop_front();
            if (got_bin !== exp_rpt.bin)
            begin
                $display("%0t: bin_index mismatch exp=%0d got=%0d",
                         $time, exp_rpt.bin, got_bin);
                errors++;
            end
            if (got_count !== exp_rpt.count)
            begin
                $display("%0t: bin_count mismatch bin=%0d exp=%0d got=%0d",
                         $time, exp_rpt.bin, exp_rpt.count, got_count);
                errors++;
            end
        endfunction
    endclass

    logic                                 clk      = 1'b0;
    logic                                 rst_n    = 1'b0;
    logic                                 s_tvalid = 1'b0;
    logic                                 s_tready;
    logic [7:0]                           s_tdata  = '0;   // [7:0] pixel_or_bin
    logic                                 s_tuser  = 1'b0; // [0] opcode
    logic                                 m_tvalid;
    logic                                 m_tready = 1'b0;
    logic [g8hist_pkg::OUT_DATA_BITS-1:0] m_tdata;  // [7:0] bin_index, [39:8] bin_count

    // Idle mix, changed per phase by the stimulus process.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    // Long output hold-off, counted down by the receiver process.
    int hold_left = 0;

    hist_scoreboard sb = new();

    gray8_histogram #(
        .COUNT_BITS(CNT_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one word. Called at a falling edge, returns at a falling edge.
    // Idle gaps go in front of the word, so they land on any pipeline phase.
    task automatic send_word(g8hist_pkg::op_t op, logic [7:0] pix);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = pix;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(op, pix);
        @(negedge clk);
    endtask

    // Half the traffic lands near a hot gray level, so bins repeat back to
    // back and the write-to-read bypass gets exercised.
    function automatic logic [7:0] pick_level(logic [7:0] hot);
        if ($urandom_range(0, 1))
            return hot + 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // One stretch of image traffic: mostly counts, about a fifth reads.
    task automatic send_image(int n_words);
        logic [7:0]      hot;
        g8hist_pkg::op_t op;
        hot = 8'($urandom_range(0, 255));
        for (int i = 0; i < n_words; i++)
        begin
            if (i % 40 == 39)
                hot = 8'($urandom_range(0, 255));
            op = ($urandom_range(0, 99) < 22) ? g8hist_pkg::OP_READ
                                              : g8hist_pkg::OP_COUNT;
            send_word(op, pick_level(hot));
        end
    endtask

    // Output side: ready set at the falling edge, word taken at the rising one.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end
            else
            begin
                m_tready = !($urandom_range(0, 99) < recv_stall_pct);
            end
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d reports outstanding", sb.pending_reads.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int waited;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme levels, alternating bit patterns, read-after-clear,
        // an untouched bin, back-to-back repeats and count-then-read.
        send_word(g8hist_pkg::OP_COUNT, 8'h00);
        send_word(g8hist_pkg::OP_COUNT, 8'hFF);
        send_word(g8hist_pkg::OP_COUNT, 8'hAA);
        send_word(g8hist_pkg::OP_COUNT, 8'h55);
        send_word(g8hist_pkg::OP_COUNT, 8'h00);
        send_word(g8hist_pkg::OP_READ,  8'h00);
        send_word(g8hist_pkg::OP_READ,  8'hFF);
        send_word(g8hist_pkg::OP_READ,  8'h00);   // cleared by the earlier read of this bin
        send_word(g8hist_pkg::OP_READ,  8'hAA);
        send_word(g8hist_pkg::OP_READ,  8'h55);
        send_word(g8hist_pkg::OP_READ,  8'h7F);   // never counted
        repeat (4) send_word(g8hist_pkg::OP_COUNT, 8'h80);
        send_word(g8hist_pkg::OP_READ,  8'h80);
        send_word(g8hist_pkg::OP_COUNT, 8'h01);
        send_word(g8hist_pkg::OP_READ,  8'h01);   // read right behind its count
        send_word(g8hist_pkg::OP_READ,  8'h01);   // back-to-back reads of one bin
        send_word(g8hist_pkg::OP_COUNT, 8'hFE);
        send_word(g8hist_pkg::OP_READ,  8'hFE);
        send_word(g8hist_pkg::OP_COUNT, 8'hFE);

        // Saturation is only reachable in reasonable time with narrow counters.
        if (CNT_BITS <= 12)
        begin
            repeat (int'((64'd1 << CNT_BITS) + 2)) send_word(g8hist_pkg::OP_COUNT, 8'h3C);
            send_word(g8hist_pkg::OP_READ, 8'h3C);
        end

        // Random traffic across the idle mixes.
        send_idle_pct = 0;  recv_stall_pct = 0;
        send_image(450);

        // Output held off for a long stretch while input keeps coming; the
        // block has to park a read and drop s_tready.
        hold_left = 250;
        send_image(120);

        send_idle_pct = 68; recv_stall_pct = 0;
        send_image(430);
        send_idle_pct = 0;  recv_stall_pct = 68;
        send_image(430);
        send_idle_pct = 7;  recv_stall_pct = 7;
        send_image(430);

        s_tvalid = 1'b0;

        waited = 0;
        while (sb.pending_reads.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending_reads.size() != 0)
        begin
            $display("%0t: %0d reports never arrived, expected 0 outstanding",
                     $time, sb.pending_reads.size());
            sb.errors++;
        end

        $display("covered %0d count words and %0d read words, %0d reports checked,",
                 sb.counts_sent, sb.reads_sent, sb.reports_seen);
        $display("under four idle mixes and one long output hold-off; %0d errors",
                 sb.errors);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
